FILE: hw/rtl/fkv_pkg.sv
package fkv_pkg;

  // Fixed widths of the item fields.
  localparam int KEY_W = 32;
  localparam int VAL_W = 32;
  localparam int CFG_W = 5;

  // Capacity after reset.
  localparam logic [CFG_W-1:0] CAP_RESET = 5'd16;

  // Operation codes.
  localparam logic OP_GET = 1'b0;
  localparam logic OP_PUT = 1'b1;

  // Value returned by a get that misses.
  localparam logic [VAL_W-1:0] MISS_VALUE = '1;

  // Step commands from the sequencer to the datapath.
  typedef struct packed {
    logic load;
    logic do_match;
    logic do_resolve;
    logic do_output;
  } fkv_cmd_t;

endpackage

FILE: hw/rtl/fkv_ctrl.sv
module fkv_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  output fkv_pkg::fkv_cmd_t cmd
);

  localparam logic [1:0] S_IDLE    = 2'd0;
  localparam logic [1:0] S_MATCH   = 2'd1;
  localparam logic [1:0] S_RESOLVE = 2'd2;
  localparam logic [1:0] S_DONE    = 2'd3;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  always_comb begin
    unique case (state_r)
      S_IDLE:    state_nxt = start ? S_MATCH : S_IDLE;
      S_MATCH:   state_nxt = S_RESOLVE;
      S_RESOLVE: state_nxt = S_DONE;
      S_DONE:    state_nxt = S_IDLE;
      default:   state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy           = (state_r != S_IDLE);
  assign cmd.load       = start && (state_r == S_IDLE);
  assign cmd.do_match   = (state_r == S_MATCH);
  assign cmd.do_resolve = (state_r == S_RESOLVE);
  assign cmd.do_output  = (state_r == S_DONE);

endmodule

FILE: hw/rtl/fkv_dpath.sv
module fkv_dpath #(
  parameter int DEPTH    = 16,
  parameter int KEY_BITS = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  fkv_pkg::fkv_cmd_t                   cmd,
  input  logic                                in_op,
  input  logic signed [fkv_pkg::KEY_W-1:0]    in_key,
  input  logic signed [fkv_pkg::VAL_W-1:0]    in_value,
  input  logic                                cfg_we,
  input  logic        [fkv_pkg::CFG_W-1:0]    cfg_wdata,
  output logic                                out_valid,
  output logic                                out_hit,
  output logic signed [fkv_pkg::VAL_W-1:0]    out_read_value,
  output logic                                out_evicted,
  output logic signed [fkv_pkg::KEY_W-1:0]    out_evicted_key
);

  localparam int KW = (KEY_BITS < fkv_pkg::KEY_W) ? KEY_BITS : fkv_pkg::KEY_W;
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int DW = $clog2(DEPTH + 1);
  localparam int EW = (DW > fkv_pkg::CFG_W) ? DW : fkv_pkg::CFG_W;
  localparam logic [EW-1:0] DEPTH_E = EW'(DEPTH);

  // Item registers.
  logic                       op_r;
  logic [KW-1:0]              key_r;
  logic [fkv_pkg::VAL_W-1:0]  val_r;

  // Store: key cells compared in parallel, copies in memories.
  logic [KW-1:0]              key_cam_r [DEPTH];
  logic [KW-1:0]              key_mem   [DEPTH];
  logic [fkv_pkg::VAL_W-1:0]  val_mem   [DEPTH];
  logic [DEPTH-1:0]           valid_r;

  logic [fkv_pkg::CFG_W-1:0]  cap_r;
  logic [PW-1:0]              ptr_r;

  // Step registers.
  logic [DEPTH-1:0]           match_r;
  logic [DEPTH-1:0]           match_nxt;
  logic [PW-1:0]              slot_r;
  logic [KW-1:0]              keyrd_r;
  logic                       hit_r;
  logic [fkv_pkg::VAL_W-1:0]  valrd_r;
  logic                       evict_r;
  logic [KW-1:0]              evk_r;

  logic                       out_valid_r;
  logic                       out_hit_r;
  logic [fkv_pkg::VAL_W-1:0]  out_read_value_r;
  logic                       out_evicted_r;
  logic [fkv_pkg::KEY_W-1:0]  out_evicted_key_r;

  logic [EW-1:0]              cap_e;
  logic [EW-1:0]              eff_cap;
  logic [PW-1:0]              slot;
  logic [EW-1:0]              slot_inc;
  logic [PW-1:0]              ptr_nxt;
  logic [PW-1:0]              found;
  logic                       any_hit;
  logic                       val_we;
  logic [PW-1:0]              val_waddr;

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      match_nxt[i] = valid_r[i] && (key_cam_r[i] == key_r);
    end
  end

  // Puts never leave two slots with the same key, so an OR of the
  // matching indexes is the matching index.
  always_comb begin
    found = '0;
    for (int i = 0; i < DEPTH; i++) begin
      found = found | (match_r[i] ? PW'(i) : PW'(0));
    end
  end

  assign any_hit = |match_r;

  // Capacity zero acts as one, anything above the depth as the depth.
  assign cap_e   = EW'(cap_r);
  assign eff_cap = (cap_r == '0) ? EW'(1) : ((cap_e > DEPTH_E) ? DEPTH_E : cap_e);
  assign slot    = (EW'(ptr_r) < eff_cap) ? ptr_r : '0;
  assign slot_inc = EW'(slot_r) + EW'(1);
  assign ptr_nxt  = (slot_inc >= eff_cap) ? '0 : PW'(slot_inc);

  assign val_we    = cmd.do_resolve && (op_r == fkv_pkg::OP_PUT);
  assign val_waddr = any_hit ? found : slot_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r  <= in_op;
      key_r <= in_key[KW-1:0];
      val_r <= in_value;
    end
    if (cmd.do_match) begin
      match_r <= match_nxt;
      slot_r  <= slot;
      keyrd_r <= key_mem[slot];
    end
    if (cmd.do_resolve) begin
      hit_r   <= any_hit;
      valrd_r <= val_mem[found];
      evk_r   <= keyrd_r;
    end
    if (val_we) begin
      val_mem[val_waddr] <= val_r;
    end
    if (val_we && !any_hit) begin
      key_mem[slot_r]   <= key_r;
      key_cam_r[slot_r] <= key_r;
    end
    if (cmd.do_output) begin
      out_hit_r <= hit_r;
      if (op_r == fkv_pkg::OP_PUT) begin
        out_read_value_r <= '0;
      end else if (hit_r) begin
        out_read_value_r <= valrd_r;
      end else begin
        out_read_value_r <= fkv_pkg::MISS_VALUE;
      end
      out_evicted_r     <= evict_r;
      out_evicted_key_r <= evict_r ? fkv_pkg::KEY_W'(evk_r) : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= '0;
      ptr_r       <= '0;
      cap_r       <= fkv_pkg::CAP_RESET;
      evict_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.do_output;
      if (cfg_we) begin
        cap_r <= cfg_wdata;
      end
      // Only a put that misses and lands on a valid slot evicts.
      if (cmd.do_resolve) begin
        evict_r <= (op_r == fkv_pkg::OP_PUT) && !any_hit && valid_r[slot_r];
      end
      if (val_we && !any_hit) begin
        valid_r[slot_r] <= 1'b1;
        ptr_r           <= ptr_nxt;
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_hit         = out_hit_r;
  assign out_read_value  = out_read_value_r;
  assign out_evicted     = out_evicted_r;
  assign out_evicted_key = out_evicted_key_r;

endmodule

FILE: hw/rtl/fifo_replacement_kv_cache.sv
// Fully associative key-value store with first-in-first-out replacement.
// Input channel: drive in_op (0 get, 1 put), in_key and in_value and raise
// start; the item is taken at a rising edge where start is high and busy is
// low. Configuration: cfg_we with cfg_wdata writes the capacity; the user
// must write it only while the block is idle, and the block itself does
// not enforce this; zero acts as one and values above DEPTH act as DEPTH.
// Result channel: out_valid is high for exactly one cycle and marks
// out_hit, out_read_value, out_evicted and out_evicted_key. The receiver
// cannot stall; a result is presented once and must be taken.
// Sequence: the item is latched at the accepting edge, then the step
// sequencer runs the parallel key compare, the step that resolves the match
// and updates the store, and the step that forms the registered result.
// Busy drops as the result strobe rises; until then no new item is taken.
// Reset (rst_n low, synchronous) clears all valid bits, the insert pointer
// and the sequencer, and sets the capacity to 16. Keys and values need no
// clearing pass; a slot's contents are only used after it has been written.
module fifo_replacement_kv_cache #(
  parameter int DEPTH    = 16,
  parameter int KEY_BITS = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic                                in_op,
  input  logic signed [fkv_pkg::KEY_W-1:0]    in_key,
  input  logic signed [fkv_pkg::VAL_W-1:0]    in_value,
  input  logic                                cfg_we,
  input  logic        [fkv_pkg::CFG_W-1:0]    cfg_wdata,
  output logic                                out_valid,
  output logic                                out_hit,
  output logic signed [fkv_pkg::VAL_W-1:0]    out_read_value,
  output logic                                out_evicted,
  output logic signed [fkv_pkg::KEY_W-1:0]    out_evicted_key
);

  // Step commands from the sequencer; the datapath needs nothing back
  // because every item walks the same fixed sequence of steps.
  fkv_pkg::fkv_cmd_t cmd;

  fkv_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .cmd   (cmd)
  );

  // The datapath holds the key cells, the key and value memories, the valid
  // bits, the ring insert pointer and the capacity register. A put that
  // misses writes the ring slot at the pointer and evicts whatever valid
  // entry sat there; a put that hits rewrites the value in place.
  fkv_dpath #(
    .DEPTH    (DEPTH),
    .KEY_BITS (KEY_BITS)
  ) u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .in_op           (in_op),
    .in_key          (in_key),
    .in_value        (in_value),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .out_valid       (out_valid),
    .out_hit         (out_hit),
    .out_read_value  (out_read_value),
    .out_evicted     (out_evicted),
    .out_evicted_key (out_evicted_key)
  );

endmodule
